@@ rtl/core/clcd_pkg.sv @@
package clcd_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_CHAR       = 2'd0,
        FUNC_SET_CURSOR = 2'd1,
        FUNC_GOTO_LINE  = 2'd2,
        FUNC_UNUSED     = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LINE_COUNT     = 2'd0,
        CFG_CHARS_PER_LINE = 2'd1,
        CFG_BUS_MODE       = 2'd2,
        CFG_NONE           = 2'd3
    } cfg_index_t;

    localparam logic [2:0] LINE_COUNT_RESET     = 3'd2;
    localparam logic [5:0] CHARS_PER_LINE_RESET = 6'd16;
    localparam logic       BUS_MODE_RESET       = 1'b0;

    localparam logic [7:0] LINE0_BASE = 8'h80;
    localparam logic [7:0] LINE1_BASE = 8'hC0;
    localparam logic [7:0] LINE2_BASE = 8'h90;
    localparam logic [7:0] LINE3_BASE = 8'hD0;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] NIBBLE_HI  = 8'hF0;
    localparam logic [5:0] COL_MAX    = 6'd63;
    localparam logic [2:0] LINE_LIMIT = 3'd3;

    localparam int MAX_XFERS = 4;
    localparam int CNT_W     = $clog2(MAX_XFERS + 1);

    typedef struct packed {
        logic [2:0] line_count;
        logic [5:0] chars_per_line;
        logic       bus_mode;
    } cfg_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] char_code;
        logic [1:0] target_line;
        logic [5:0] target_column;
    } req_t;

    // one bus transfer
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
    } xfer_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        xfer_t [MAX_XFERS-1:0]       xfer;
    } plan_t;

    // ddram base address of a display line
    function automatic logic [7:0] line_base(input logic [1:0] line, input cfg_t cfg);
        logic [7:0] off;
        logic [7:0] base;
        begin
            off = (cfg.line_count > 3'd2) ? {4'd0, cfg.chars_per_line[3:0]} : 8'd0;
            case (line)
                2'd0:    base = LINE0_BASE;
                2'd1:    base = LINE1_BASE;
                2'd2:    base = LINE2_BASE + off;
                default: base = LINE3_BASE + off;
            endcase
            return base;
        end
    endfunction

endpackage

@@ rtl/core/clcd_cursor.sv @@
module clcd_cursor
    import clcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  req_t  req,
    input  logic  step,
    output plan_t plan
);

    logic [1:0] line_reg, line_next;
    logic [5:0] col_reg, col_next;

    logic [1:0] byte_cnt;
    logic [1:0] byte_rs;
    logic [7:0] byte_val [2];
    logic       wrap;
    logic [2:0] nl;
    logic [1:0] nl_line;
    logic       line_ok;
    logic       col_ok;

    // bytes caused by the request and the new cursor position
    always_comb
    begin
        byte_cnt    = 2'd0;
        byte_rs     = 2'b00;
        byte_val[0] = 8'd0;
        byte_val[1] = 8'd0;
        line_next   = line_reg;
        col_next    = col_reg;
        wrap        = (col_reg >= cfg.chars_per_line) || (req.char_code == NEWLINE);
        nl          = {1'b0, line_reg} + 3'd1;
        nl_line     = ((nl >= cfg.line_count) || (nl > LINE_LIMIT)) ? 2'd0 : nl[1:0];
        line_ok     = {1'b0, req.target_line} < cfg.line_count;
        col_ok      = req.target_column < cfg.chars_per_line;
        unique case (req.func)
            FUNC_CHAR:
            begin
                if (wrap)
                begin
                    line_next   = nl_line;
                    col_next    = 6'd0;
                    byte_val[0] = line_base(nl_line, cfg);
                    byte_cnt    = 2'd1;
                end
                if (req.char_code != NEWLINE)
                begin
                    byte_rs[byte_cnt[0]]  = 1'b1;
                    byte_val[byte_cnt[0]] = req.char_code;
                    byte_cnt              = byte_cnt + 2'd1;
                    if (wrap)
                        col_next = 6'd1;
                    else if (col_reg < COL_MAX)
                        col_next = col_reg + 6'd1;
                end
            end
            FUNC_SET_CURSOR:
            begin
                if (line_ok && col_ok)
                begin
                    line_next   = req.target_line;
                    col_next    = req.target_column;
                    byte_val[0] = line_base(req.target_line, cfg) + {2'd0, req.target_column};
                    byte_cnt    = 2'd1;
                end
            end
            FUNC_GOTO_LINE:
            begin
                if (line_ok)
                begin
                    line_next   = req.target_line;
                    col_next    = 6'd0;
                    byte_val[0] = line_base(req.target_line, cfg);
                    byte_cnt    = 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // split bytes into bus transfers
    always_comb
    begin
        plan = '0;
        if (cfg.bus_mode)
        begin
            plan.count = {byte_cnt, 1'b0};
            for (int i = 0; i < 2; i++)
            begin
                plan.xfer[2*i].rs      = byte_rs[i];
                plan.xfer[2*i].value   = byte_val[i] & NIBBLE_HI;
                plan.xfer[2*i+1].rs    = byte_rs[i];
                plan.xfer[2*i+1].value = {byte_val[i][3:0], 4'd0};
            end
        end
        else
        begin
            plan.count = {1'b0, byte_cnt};
            for (int i = 0; i < 2; i++)
            begin
                plan.xfer[i].rs    = byte_rs[i];
                plan.xfer[i].value = byte_val[i];
            end
        end
    end

    // cursor position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= 2'd0;
            col_reg  <= 6'd0;
        end
        else if (step)
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

@@ rtl/core/char_lcd_cursor_sequencer.sv @@
// Character LCD cursor sequencer: turns character and cursor requests into
// command and data transfers for a character LCD bus.
// Input channel s_*: one request per item; tuser carries the request kind
// (display character, set cursor, go to line start), tdata its operands.
// Output channel m_*: one bus transfer per item; tuser is register select
// (0 command, 1 data), tlast marks the final transfer of a request.
// Configuration: cfg_we/cfg_addr/cfg_wdata write line count, characters per
// line and bus mode; write only while no request is in flight.
// With the output register free, a request accepted into the input register
// is loaded into the output register, which then holds its first transfer
// valid. A request yields 0 to 4 transfers and the output register drains
// one transfer per cycle while m_tready is high.
// The input register takes the next request while the previous one still
// drains, so a downstream stall first fills the output register, then the
// input register, then drops s_tready.
// Reset puts the cursor at line 0 column 0, clears both registers and loads
// the defaults: two lines, sixteen characters per line, eight-bit bus.
module char_lcd_cursor_sequencer
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[7:0], target_line[9:8], target_column[15:10]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // bus transfer output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_value[7:0]
    output logic        m_tuser,   // register_select[0]
    output logic        m_tlast,
    // configuration write
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata
);

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    req_t                  in_req_reg;
    logic [CNT_W-1:0]      out_cnt_reg, out_cnt_next;
    xfer_t [MAX_XFERS-1:0] out_xfer_reg, out_xfer_next;

    plan_t plan;
    logic  load;
    logic  out_take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_count     <= LINE_COUNT_RESET;
            cfg_reg.chars_per_line <= CHARS_PER_LINE_RESET;
            cfg_reg.bus_mode       <= BUS_MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_LINE_COUNT:     cfg_reg.line_count     <= cfg_wdata[2:0];
                CFG_CHARS_PER_LINE: cfg_reg.chars_per_line <= cfg_wdata;
                CFG_BUS_MODE:       cfg_reg.bus_mode       <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake control
    assign out_take = m_tvalid && m_tready;
    assign load     = in_valid_reg
                      && ((out_cnt_reg == '0) || ((out_cnt_reg == CNT_W'(1)) && m_tready));
    assign s_tready = !in_valid_reg || load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg.func          <= func_t'(s_tuser);
            in_req_reg.char_code     <= s_tdata[7:0];
            in_req_reg.target_line   <= s_tdata[9:8];
            in_req_reg.target_column <= s_tdata[15:10];
        end
    end

    // cursor tracking and transfer plan
    clcd_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (in_req_reg),
        .step  (load),
        .plan  (plan)
    );

    // output register: loads a plan, then shifts one transfer out per item taken
    always_comb
    begin
        out_cnt_next  = out_cnt_reg;
        out_xfer_next = out_xfer_reg;
        if (load)
        begin
            out_cnt_next  = plan.count;
            out_xfer_next = plan.xfer;
        end
        else if (out_take)
        begin
            out_cnt_next  = out_cnt_reg - CNT_W'(1);
            out_xfer_next = {xfer_t'('0), out_xfer_reg[MAX_XFERS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_cnt_reg <= '0;
        else
            out_cnt_reg <= out_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        out_xfer_reg <= out_xfer_next;
    end

    assign m_tvalid = out_cnt_reg != '0;
    assign m_tdata  = out_xfer_reg[0].value;
    assign m_tuser  = out_xfer_reg[0].rs;
    assign m_tlast  = out_cnt_reg == CNT_W'(1);

`ifndef ASSERT_OFF
    // four-bit bus always gives nibble pairs
    a_nibble_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cfg_reg.bus_mode) |-> !plan.count[0])
        else $error("odd transfer count on four-bit bus");

    // eight-bit bus gives at most two transfers per request
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cfg_reg.bus_mode) |-> (plan.count <= CNT_W'(2)))
        else $error("too many transfers on eight-bit bus");

    // transfers of one request follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !m_tlast) |=> m_tvalid)
        else $error("gap inside a transfer run");

    // a new plan is loaded only when the output register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!m_tvalid || (m_tlast && m_tready)))
        else $error("plan loaded over pending transfers");
`endif

endmodule

@@ test/char_lcd_cursor_sequencer_tb.sv @@
module char_lcd_cursor_sequencer_tb;
    import clcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 8;
    localparam int CHUNK_ITEMS   = 19;

    // one expected bus transfer
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       last;
    } bus_xfer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // char_code[7:0], target_line[9:8], target_column[15:10]
    logic [1:0]  s_tuser = '0;    // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // bus_value[7:0]
    logic        m_tuser;         // register_select[0]
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [5:0]  cfg_wdata = '0;

    // shadow copy of the configuration registers
    logic [2:0] lines_cfg   = LINE_COUNT_RESET;
    logic [5:0] cols_cfg    = CHARS_PER_LINE_RESET;
    logic       nibble_mode = BUS_MODE_RESET;

    // tracked cursor
    logic [1:0] track_line = '0;
    logic [5:0] track_col  = '0;

    req_t      request_q[$];
    bus_xfer_t due_xfers[$];
    bus_xfer_t plan[4];
    int        plan_n;

    req_t      cur_req;
    bus_xfer_t due;
    int        tx_wait = 0;
    int        rx_wait = 0;
    int        tx_max_gap = 4;
    int        rx_max_stall = 4;
    int        n_items = 0;
    int        n_xfers = 0;
    int        n_errors = 0;
    int        cycle_count = 0;

    char_lcd_cursor_sequencer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ddram address of the first column of a line
    function automatic logic [7:0] line_addr(input logic [1:0] line);
        logic [7:0] offset;
        offset = (lines_cfg > 3'd2) ? {4'd0, cols_cfg[3:0]} : 8'd0;
        case (line)
            2'd0:    return LINE0_BASE;
            2'd1:    return LINE1_BASE;
            2'd2:    return LINE2_BASE + offset;
            default: return LINE3_BASE + offset;
        endcase
    endfunction

    // one byte becomes one transfer, or two nibble transfers on a 4-bit bus
    task automatic add_byte(input logic rs, input logic [7:0] b);
        if (nibble_mode)
        begin
            plan[plan_n] = '{rs, b & NIBBLE_HI, 1'b0};
            plan[plan_n + 1] = '{rs, {b[3:0], 4'd0}, 1'b0};
            plan_n += 2;
        end
        else
        begin
            plan[plan_n] = '{rs, b, 1'b0};
            plan_n += 1;
        end
    endtask

    // move to the start of the next line, wrapping to line 0
    task automatic advance_line();
        logic [2:0] nl;
        nl = {1'b0, track_line} + 3'd1;
        if (nl >= lines_cfg || nl > LINE_LIMIT)
            nl = 3'd0;
        track_line = nl[1:0];
        track_col = '0;
        add_byte(1'b0, line_addr(nl[1:0]));
    endtask

    // expected transfers of one accepted request, cursor updated on the way
    task automatic predict_transfers(input req_t r);
        plan_n = 0;
        case (r.func)
            FUNC_CHAR:
            begin
                if (track_col >= cols_cfg || r.char_code == NEWLINE)
                    advance_line();
                if (r.char_code != NEWLINE)
                begin
                    add_byte(1'b1, r.char_code);
                    if (track_col < COL_MAX)
                        track_col = track_col + 6'd1;
                end
            end
            FUNC_SET_CURSOR:
            begin
                if ({1'b0, r.target_line} < lines_cfg && r.target_column < cols_cfg)
                begin
                    track_line = r.target_line;
                    track_col = r.target_column;
                    add_byte(1'b0, line_addr(r.target_line) + {2'd0, r.target_column});
                end
            end
            FUNC_GOTO_LINE:
            begin
                if ({1'b0, r.target_line} < lines_cfg)
                begin
                    track_line = r.target_line;
                    track_col = '0;
                    add_byte(1'b0, line_addr(r.target_line));
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < plan_n; i++)
            due_xfers.push_back('{plan[i].rs, plan[i].value, i == plan_n - 1});
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_transfers(cur_req);
                n_items++;
                tx_wait = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    cur_req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.target_column, cur_req.target_line, cur_req.char_code};
                    s_tuser <= cur_req.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // transfer monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_xfers++;
                if (due_xfers.size() == 0)
                    report_mismatch($sformatf("unexpected transfer rs %0b value %02h last %0b",
                                              m_tuser, m_tdata, m_tlast));
                else
                begin
                    due = due_xfers.pop_front();
                    if (m_tuser !== due.rs)
                        report_mismatch($sformatf("transfer %0d: register select %0b, want %0b",
                                                  n_xfers, m_tuser, due.rs));
                    if (m_tdata !== due.value)
                        report_mismatch($sformatf("transfer %0d: bus value %02h, want %02h",
                                                  n_xfers, m_tdata, due.value));
                    if (m_tlast !== due.last)
                        report_mismatch($sformatf("transfer %0d: last %0b, want %0b",
                                                  n_xfers, m_tlast, due.last));
                end
                rx_wait = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
            end
            else if (rx_wait > 0)
                rx_wait--;
            m_tready <= (rx_wait == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d transfers still due",
                     cycle_count, due_xfers.size());
            $display("char_lcd_cursor_sequencer test failed");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [5:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // write all three registers, upper write-data bits filled with junk
    task automatic apply_settings(input logic [2:0] lc, input logic [5:0] cpl, input logic bm);
        logic [2:0] junk_lc;
        logic [4:0] junk_bm;
        junk_lc = 3'($urandom_range(0, 7));
        junk_bm = 5'($urandom_range(0, 31));
        write_reg(CFG_LINE_COUNT, {junk_lc, lc});
        write_reg(CFG_CHARS_PER_LINE, cpl);
        write_reg(CFG_BUS_MODE, {junk_bm, bm});
        lines_cfg = lc;
        cols_cfg = cpl;
        nibble_mode = bm;
        @(negedge clk);
    endtask

    task automatic queue_req(input func_t f, input logic [7:0] c, input logic [1:0] l,
                             input logic [5:0] col);
        req_t r;
        r.func = f;
        r.char_code = c;
        r.target_line = l;
        r.target_column = col;
        request_q.push_back(r);
    endtask

    // wait until every request is taken and every transfer has arrived
    task automatic settle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || due_xfers.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly characters and in-range cursor moves, some noise
    function automatic req_t random_req();
        req_t r;
        int   pick;
        int   top_line;
        int   span;
        pick = $urandom_range(0, 99);
        r.char_code = 8'($urandom_range(0, 255));
        r.target_line = 2'($urandom_range(0, 3));
        r.target_column = 6'($urandom_range(0, 63));
        top_line = (lines_cfg > 3'd4) ? 4 : int'(lines_cfg);
        if (pick < 55)
        begin
            r.func = FUNC_CHAR;
            if ($urandom_range(0, 9) == 0)
                r.char_code = NEWLINE;
        end
        else if (pick < 75)
        begin
            r.func = FUNC_SET_CURSOR;
            if ($urandom_range(0, 3) != 0 && top_line != 0 && cols_cfg != 0)
            begin
                r.target_line = 2'($urandom_range(0, top_line - 1));
                // half of them land near the end of the line
                span = (cols_cfg > 6'd4) ? 3 : int'(cols_cfg) - 1;
                if ($urandom_range(0, 1) == 0)
                    r.target_column = cols_cfg - 6'd1 - 6'($urandom_range(0, span));
                else
                    r.target_column = 6'($urandom_range(0, int'(cols_cfg) - 1));
            end
        end
        else if (pick < 95)
        begin
            r.func = FUNC_GOTO_LINE;
            if ($urandom_range(0, 3) != 0 && top_line != 0)
                r.target_line = 2'($urandom_range(0, top_line - 1));
        end
        else
            r.func = FUNC_UNUSED;
        return r;
    endfunction

    task automatic queue_random(input int n, input int gap, input int stall);
        tx_max_gap = gap;
        rx_max_stall = stall;
        for (int i = 0; i < n; i++)
            request_q.push_back(random_req());
    endtask

    // stimulus
    initial
    begin
        logic [2:0] set_lc;
        logic [5:0] set_cpl;
        logic       set_bm;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: two lines of sixteen, eight-bit bus
        queue_req(FUNC_CHAR, 8'h41, 2'd0, 6'd0);
        queue_req(FUNC_SET_CURSOR, 8'h00, 2'd1, 6'd15);
        queue_req(FUNC_CHAR, 8'hFF, 2'd3, 6'd63);
        queue_req(FUNC_CHAR, 8'h00, 2'd0, 6'd0);
        queue_req(FUNC_CHAR, NEWLINE, 2'd0, 6'd0);
        queue_req(FUNC_CHAR, NEWLINE, 2'd2, 6'd21);
        queue_req(FUNC_GOTO_LINE, 8'h00, 2'd1, 6'd0);
        queue_req(FUNC_GOTO_LINE, 8'hFF, 2'd2, 6'd63);
        queue_req(FUNC_SET_CURSOR, 8'h00, 2'd0, 6'd16);
        queue_req(FUNC_SET_CURSOR, 8'h00, 2'd3, 6'd63);
        queue_req(FUNC_SET_CURSOR, 8'h00, 2'd1, 6'd0);
        queue_req(FUNC_UNUSED, 8'hFF, 2'd3, 6'd63);
        queue_req(FUNC_SET_CURSOR, 8'h00, 2'd0, 6'd15);
        queue_req(FUNC_CHAR, 8'h55, 2'd0, 6'd0);
        queue_req(FUNC_CHAR, 8'hAA, 2'd0, 6'd0);
        settle();

        // unmapped register index must change nothing
        write_reg(CFG_NONE, 6'h3F);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin set_lc = 3'd4; set_cpl = 6'd40; set_bm = 1'b1; end
                1: begin set_lc = 3'd1; set_cpl = 6'd1;  set_bm = 1'b0; end
                2: begin set_lc = 3'd0; set_cpl = 6'd0;  set_bm = 1'b1; end
                3: begin set_lc = 3'd7; set_cpl = 6'd63; set_bm = 1'b0; end
                4: begin set_lc = 3'd3; set_cpl = 6'd20; set_bm = 1'b1; end
                default:
                begin
                    set_lc = 3'($urandom_range(0, 7));
                    set_cpl = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                           : 6'($urandom_range(1, 40));
                    set_bm = 1'($urandom_range(0, 1));
                end
            endcase
            apply_settings(set_lc, set_cpl, set_bm);

            // four lines, four-bit bus: offset line addresses and the wrap from line 3
            if (ph == 0)
            begin
                queue_req(FUNC_SET_CURSOR, 8'h00, 2'd3, 6'd39);
                queue_req(FUNC_CHAR, 8'h5A, 2'd0, 6'd0);
                queue_req(FUNC_CHAR, 8'hA5, 2'd0, 6'd0);
                queue_req(FUNC_GOTO_LINE, 8'h00, 2'd2, 6'd0);
                queue_req(FUNC_GOTO_LINE, 8'h00, 2'd3, 6'd0);
                queue_req(FUNC_CHAR, NEWLINE, 2'd0, 6'd0);
            end

            // first half, then a full drain before the second half
            if (ph % 2 == 0)
                queue_random(CHUNK_ITEMS, 4, 4);
            else
                queue_random(CHUNK_ITEMS, 0, 0);
            settle();
            if (ph % 2 == 0)
                queue_random(CHUNK_ITEMS, 0, 4);
            else
                queue_random(CHUNK_ITEMS, 4, 0);
            settle();
        end

        $display("%0d requests over %0d register settings, %0d bus transfers checked",
                 n_items, PHASES + 1, n_xfers);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0)
            $display("char_lcd_cursor_sequencer test passed");
        else
            $display("char_lcd_cursor_sequencer test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/clcd_pkg.sv
rtl/core/clcd_cursor.sv
rtl/core/char_lcd_cursor_sequencer.sv
test/char_lcd_cursor_sequencer_tb.sv
